// ----- rtl/core/mesh_tangent_space_builder_assert.svh -----
// ----------------------------------------------------------------------------
// Mesh tangent space builder: assertion macros
// Shorthand for the clocked, reset-gated checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MESH_TANGENT_SPACE_BUILDER_ASSERT_SVH
`define MESH_TANGENT_SPACE_BUILDER_ASSERT_SVH

// same-cycle implication
`define MTSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MTSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/mtsb_pkg.sv -----
// ----------------------------------------------------------------------------
// Mesh tangent space builder: shared package
// Field widths, arithmetic unit widths, mode codes and the sequencer states.
// ----------------------------------------------------------------------------
package mtsb_pkg;

	localparam int ACC_W  = 40;   // Q26.14 accumulator, saturating
	localparam int POS_W  = 32;   // Q16.16
	localparam int UV_W   = 16;   // Q4.12
	localparam int OUT_W  = 16;   // Q2.14 result
	localparam int DLT_W  = 17;   // uv delta
	localparam int EDGE_W = 33;   // position delta
	localparam int DET_W  = 35;   // uv determinant
	localparam int NUM_W  = 51;   // face numerator
	localparam int MUL_W  = 34;   // shared multiplier operand
	localparam int DIV_NW = 62;   // divider dividend and quotient
	localparam int DIV_DW = 35;   // divider divisor
	localparam int SQ_W   = 64;   // square root radicand
	localparam int RT_W   = 32;   // square root result
	localparam int NRM_W  = 30;   // magnitude limit before squaring

	localparam int POS_MW = 3 * POS_W + 2 * UV_W;
	localparam int ACC_MW = 6 * ACC_W;

	localparam int MUL_STEPS = 14; // seven terms, two products each

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	localparam logic [1:0] MODE_LOAD_PU  = 2'd0;
	localparam logic [1:0] MODE_LOAD_VEC = 2'd1;
	localparam logic [1:0] MODE_TRI      = 2'd2;
	localparam logic [1:0] MODE_READ     = 2'd3;

	typedef enum logic [4:0] {
		S_IDLE,
		S_T_RDA,
		S_T_RDB,
		S_T_RDC,
		S_T_DLT,
		S_T_MUL,
		S_T_CHK,
		S_F_GO,
		S_F_WAIT,
		S_A_RD,
		S_A_WR,
		S_R_RD,
		S_R_CAP,
		S_N_MAG,
		S_N_SH,
		S_N_SQ,
		S_N_RT_GO,
		S_N_RT_WAIT,
		S_D_GO,
		S_D_WAIT,
		S_R_FIN
	} st_t;

endpackage

// ----- rtl/core/mtsb_div.sv -----
// ----------------------------------------------------------------------------
// Mesh tangent space builder: serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtsb_div import mtsb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIV_NW-1:0] dividend,
	input  logic [DIV_DW-1:0] divisor,
	output logic              done,
	output logic [DIV_NW-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_NW);

	logic              run_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] dv_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, dv_q};
	assign ge    = trial >= {1'b0, dv_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_NW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out of the top as quotient bits shift in
	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dv_q  <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/mtsb_isqrt.sv -----
// ----------------------------------------------------------------------------
// Mesh tangent space builder: integer square root
// Digit-by-digit floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module mtsb_isqrt import mtsb_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [SQ_W-1:0] radicand,
	output logic            done,
	output logic [RT_W-1:0] root
);

	logic            run_q;
	logic            done_q;
	logic [SQ_W-1:0] x_q;
	logic [SQ_W-1:0] r_q;
	logic [SQ_W-1:0] b_q;
	logic [SQ_W-1:0] trial;
	logic            ge;

	assign trial = r_q + b_q;
	assign ge    = x_q >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
			end else if (run_q && b_q[0]) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q <= radicand;
			r_q <= '0;
			b_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (run_q) begin
			if (ge) begin
				x_q <= x_q - trial;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = RT_W'(r_q);

endmodule

// ----- rtl/core/mesh_tangent_space_builder.sv -----
// ----------------------------------------------------------------------------
// Mesh tangent space builder
// Load words (position/uv, starting vectors) write the store in the accept
// cycle and keep the block idle. A triangle with a nonzero uv determinant
// runs six divisions on the shared serial divider. A read runs, per nonzero
// vector, the truncating shifts, one square root and three divisions. The
// result strobe is registered from the final sequencer state.
// Reset clears only the sequencer; stores are undefined until written.
// ----------------------------------------------------------------------------
`include "mesh_tangent_space_builder_assert.svh"

module mesh_tangent_space_builder import mtsb_pkg::*; #(
	parameter int VERTEX_COUNT = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              mode,
	input  logic [9:0]              vertex_index,
	input  logic [9:0]              corner_b_index,
	input  logic [9:0]              corner_c_index,
	input  logic signed [POS_W-1:0] vec_x,
	input  logic signed [POS_W-1:0] vec_y,
	input  logic signed [POS_W-1:0] vec_z,
	input  logic signed [UV_W-1:0]  tex_u,
	input  logic signed [UV_W-1:0]  tex_v,
	input  logic signed [OUT_W-1:0] vec2_x,
	input  logic signed [OUT_W-1:0] vec2_y,
	input  logic signed [OUT_W-1:0] vec2_z,
	output logic                    done,
	output logic signed [OUT_W-1:0] tangent_x,
	output logic signed [OUT_W-1:0] tangent_y,
	output logic signed [OUT_W-1:0] tangent_z,
	output logic signed [OUT_W-1:0] bitangent_x,
	output logic signed [OUT_W-1:0] bitangent_y,
	output logic signed [OUT_W-1:0] bitangent_z,
	output logic                    zero_vector
);

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam logic [DIV_NW-1:0] FACE_LIM = DIV_NW'(ACC_MAX);

	st_t state_q, state_d;

	logic          accept;
	logic          a_ok, b_ok, c_ok;
	logic [AW-1:0] ia_q, ib_q, ic_q, corner_addr;
	logic [1:0]    cidx_q;

	// vertex stores
	logic [POS_MW-1:0] pos_mem [VERTEX_COUNT];
	logic [ACC_MW-1:0] acc_mem [VERTEX_COUNT];
	logic [POS_MW-1:0] pos_rd_q, pa_q, pb_q;
	logic [ACC_MW-1:0] acc_rd_q, acc_wdata, acc_wdata_tri, acc_wdata_vec;
	logic [AW-1:0]     pos_raddr, acc_raddr, acc_waddr;
	logic              pos_we, vec_we, acc_we, acc_wr_tri;

	// triangle datapath
	logic signed [DLT_W-1:0]   du1_q, dv1_q, du2_q, dv2_q;
	logic signed [EDGE_W-1:0]  e1_q [3];
	logic signed [EDGE_W-1:0]  e2_q [3];
	logic [3:0]                k_q, kk;
	logic [2:0]                jj, ti, bi;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] prod_s1;
	logic signed [NUM_W-1:0]   first_q, term_d;
	logic signed [DET_W-1:0]   det_q;
	logic signed [NUM_W-1:0]   num_q [6];
	logic signed [NUM_W-1:0]   num_sel;
	logic [NUM_W-1:0]          n_mag;
	logic [DET_W-1:0]          d_mag;
	logic                      face_neg;
	logic signed [ACC_W-1:0]   face_v;
	logic signed [ACC_W-1:0]   face_q [6];
	logic signed [ACC_W:0]     acc_sum [6];
	logic [2:0]                j_q;

	// shared units
	logic              div_go, div_done;
	logic [DIV_NW-1:0] div_dividend, div_quo;
	logic [DIV_DW-1:0] div_divisor;
	logic              rt_go, rt_done;
	logic [RT_W-1:0]   rt_root;

	// read datapath
	logic signed [ACC_W-1:0] v_q [6];
	logic signed [ACC_W-1:0] cur_v [3];
	logic [ACC_W-1:0]        mag_c [3];
	logic [ACC_W-1:0]        m_q [3];
	logic [ACC_W-1:0]        mx_c, mx_q;
	logic                    sel_q;
	logic [SQ_W-1:0]         sum_q;
	logic [RT_W-1:0]         n_q;
	logic                    norm_neg;
	logic [OUT_W-1:0]        res_v;
	logic [2:0]              ridx;
	logic signed [OUT_W-1:0] res_q [6];
	logic                    zf_q;
	logic                    done_q;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign a_ok   = {22'd0, vertex_index} < 32'(VERTEX_COUNT);
	assign b_ok   = {22'd0, corner_b_index} < 32'(VERTEX_COUNT);
	assign c_ok   = {22'd0, corner_c_index} < 32'(VERTEX_COUNT);

	assign corner_addr = (cidx_q == 2'd0) ? ia_q : (cidx_q == 2'd1) ? ib_q : ic_q;

	// ---------------- stores ----------------
	assign pos_we = accept && (mode == MODE_LOAD_PU) && a_ok;
	assign vec_we = accept && (mode == MODE_LOAD_VEC) && a_ok;
	assign acc_we = vec_we || acc_wr_tri;

	assign acc_wdata_vec = {ACC_W'(vec_x), ACC_W'(vec_y), ACC_W'(vec_z),
		ACC_W'(vec2_x), ACC_W'(vec2_y), ACC_W'(vec2_z)};
	assign acc_wdata = acc_wr_tri ? acc_wdata_tri : acc_wdata_vec;
	assign acc_waddr = acc_wr_tri ? corner_addr : AW'(vertex_index);

	always_ff @(posedge clk) begin
		if (pos_we)
			pos_mem[AW'(vertex_index)] <= {vec_x, vec_y, vec_z, tex_u, tex_v};
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we)
			acc_mem[acc_waddr] <= acc_wdata;
		acc_rd_q <= acc_mem[acc_raddr];
	end

	// saturating add of the face values into the corner just read
	always_comb begin
		for (int e = 0; e < 6; e++) begin
			acc_sum[e] = {acc_rd_q[(5-e)*ACC_W + ACC_W - 1], acc_rd_q[(5-e)*ACC_W +: ACC_W]}
				+ {face_q[e][ACC_W-1], face_q[e]};
			if (acc_sum[e][ACC_W] != acc_sum[e][ACC_W-1])
				acc_wdata_tri[(5-e)*ACC_W +: ACC_W] = acc_sum[e][ACC_W] ? ACC_MIN : ACC_MAX;
			else
				acc_wdata_tri[(5-e)*ACC_W +: ACC_W] = acc_sum[e][ACC_W-1:0];
		end
	end

	// ---------------- shared multiplier ----------------
	assign kk = k_q - 4'd1;
	assign jj = k_q[3:1];
	assign ti = jj - 3'd1;
	assign bi = jj - 3'd4;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_N_SQ) begin
			if (k_q < 4'd3) begin
				mul_a = MUL_W'(m_q[k_q[1:0]]);
				mul_b = MUL_W'(m_q[k_q[1:0]]);
			end
		end else begin
			case (jj)
				3'd0: begin
					mul_a = k_q[0] ? MUL_W'(du2_q) : MUL_W'(du1_q);
					mul_b = k_q[0] ? MUL_W'(dv1_q) : MUL_W'(dv2_q);
				end
				3'd1, 3'd2, 3'd3: begin
					mul_a = k_q[0] ? MUL_W'(dv1_q) : MUL_W'(dv2_q);
					mul_b = k_q[0] ? MUL_W'(e2_q[ti[1:0]]) : MUL_W'(e1_q[ti[1:0]]);
				end
				3'd4, 3'd5, 3'd6: begin
					mul_a = k_q[0] ? MUL_W'(du2_q) : MUL_W'(du1_q);
					mul_b = k_q[0] ? MUL_W'(e1_q[bi[1:0]]) : MUL_W'(e2_q[bi[1:0]]);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	assign term_d = first_q - NUM_W'(prod_s1);

	// ---------------- division operands ----------------
	assign num_sel = num_q[j_q];
	assign n_mag   = num_sel[NUM_W-1] ? NUM_W'(-num_sel) : NUM_W'(num_sel);
	assign d_mag   = det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);

	always_comb begin
		if (state_q == S_F_GO) begin
			div_dividend = (DIV_NW'(n_mag) << 10) + DIV_NW'(d_mag >> 1);
			div_divisor  = DIV_DW'(d_mag);
		end else begin
			div_dividend = (DIV_NW'(m_q[j_q[1:0]]) << 14) + DIV_NW'(n_q >> 1);
			div_divisor  = DIV_DW'(n_q);
		end
	end

	// rounded quotient to a saturated signed face value
	assign face_neg = num_sel[NUM_W-1] ^ det_q[DET_W-1];
	always_comb begin
		if (face_neg)
			face_v = (div_quo > FACE_LIM + 1'b1) ? ACC_MIN : -$signed(div_quo[ACC_W-1:0]);
		else
			face_v = (div_quo > FACE_LIM) ? ACC_MAX : $signed(div_quo[ACC_W-1:0]);
	end

	mtsb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	mtsb_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (rt_go),
		.radicand (sum_q),
		.done     (rt_done),
		.root     (rt_root)
	);

	// ---------------- normalisation helpers ----------------
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cur_v[i] = sel_q ? v_q[3+i] : v_q[i];
			mag_c[i] = cur_v[i][ACC_W-1] ? ACC_W'(-cur_v[i]) : ACC_W'(cur_v[i]);
		end
		mx_c = mag_c[0];
		if (mag_c[1] > mx_c)
			mx_c = mag_c[1];
		if (mag_c[2] > mx_c)
			mx_c = mag_c[2];
	end

	assign norm_neg = cur_v[j_q[1:0]][ACC_W-1];
	assign res_v    = norm_neg ? (~div_quo[OUT_W-1:0] + 1'b1) : div_quo[OUT_W-1:0];
	assign ridx     = sel_q ? (j_q + 3'd3) : j_q;

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_R_FIN);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (mode == MODE_TRI && a_ok && b_ok && c_ok)
						state_d = S_T_RDA;
					else if (mode == MODE_READ && a_ok)
						state_d = S_R_RD;
				end
			end
			S_T_RDA: state_d = S_T_RDB;
			S_T_RDB: state_d = S_T_RDC;
			S_T_RDC: state_d = S_T_DLT;
			S_T_DLT: state_d = S_T_MUL;
			S_T_MUL: begin
				if (k_q == 4'(MUL_STEPS))
					state_d = S_T_CHK;
			end
			S_T_CHK: state_d = (det_q == '0) ? S_IDLE : S_F_GO;
			S_F_GO: state_d = S_F_WAIT;
			S_F_WAIT: begin
				if (div_done)
					state_d = (j_q == 3'd5) ? S_A_RD : S_F_GO;
			end
			S_A_RD: state_d = S_A_WR;
			S_A_WR: state_d = (cidx_q == 2'd2) ? S_IDLE : S_A_RD;
			S_R_RD: state_d = S_R_CAP;
			S_R_CAP: state_d = S_N_MAG;
			S_N_MAG: begin
				if (mx_c == '0)
					state_d = sel_q ? S_R_FIN : S_N_MAG;
				else
					state_d = S_N_SH;
			end
			S_N_SH: begin
				if (mx_q[ACC_W-1:NRM_W] == '0)
					state_d = S_N_SQ;
			end
			S_N_SQ: begin
				if (k_q == 4'd3)
					state_d = S_N_RT_GO;
			end
			S_N_RT_GO: state_d = S_N_RT_WAIT;
			S_N_RT_WAIT: begin
				if (rt_done)
					state_d = S_D_GO;
			end
			S_D_GO: state_d = S_D_WAIT;
			S_D_WAIT: begin
				if (div_done) begin
					if (j_q == 3'd2)
						state_d = sel_q ? S_R_FIN : S_N_MAG;
					else
						state_d = S_D_GO;
				end
			end
			S_R_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		pos_raddr  = ia_q;
		acc_raddr  = ia_q;
		div_go     = 1'b0;
		rt_go      = 1'b0;
		acc_wr_tri = 1'b0;
		case (state_q)
			S_T_RDB: pos_raddr = ib_q;
			S_T_RDC: pos_raddr = ic_q;
			S_A_RD: acc_raddr = corner_addr;
			S_A_WR: acc_wr_tri = 1'b1;
			S_F_GO, S_D_GO: div_go = 1'b1;
			S_N_RT_GO: rt_go = 1'b1;
			default: ;
		endcase
	end

	// ---------------- datapath ----------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ia_q <= AW'(vertex_index);
					ib_q <= AW'(corner_b_index);
					ic_q <= AW'(corner_c_index);
				end
			end
			S_T_RDB: pa_q <= pos_rd_q;
			S_T_RDC: pb_q <= pos_rd_q;
			S_T_DLT: begin
				// corner c is on the read port now
				du1_q <= DLT_W'($signed(pb_q[UV_W +: UV_W])) - DLT_W'($signed(pa_q[UV_W +: UV_W]));
				dv1_q <= DLT_W'($signed(pb_q[0 +: UV_W])) - DLT_W'($signed(pa_q[0 +: UV_W]));
				du2_q <= DLT_W'($signed(pos_rd_q[UV_W +: UV_W]))
					- DLT_W'($signed(pa_q[UV_W +: UV_W]));
				dv2_q <= DLT_W'($signed(pos_rd_q[0 +: UV_W])) - DLT_W'($signed(pa_q[0 +: UV_W]));
				for (int i = 0; i < 3; i++) begin
					e1_q[i] <= EDGE_W'($signed(pb_q[POS_MW - POS_W*(i+1) +: POS_W]))
						- EDGE_W'($signed(pa_q[POS_MW - POS_W*(i+1) +: POS_W]));
					e2_q[i] <= EDGE_W'($signed(pos_rd_q[POS_MW - POS_W*(i+1) +: POS_W]))
						- EDGE_W'($signed(pa_q[POS_MW - POS_W*(i+1) +: POS_W]));
				end
				k_q <= '0;
			end
			S_T_MUL: begin
				k_q <= k_q + 1'b1;
				if (k_q != '0) begin
					if (!kk[0])
						first_q <= NUM_W'(prod_s1);
					else if (kk[3:1] == 3'd0)
						det_q <= DET_W'(term_d);
					else
						num_q[kk[3:1] - 3'd1] <= term_d;
				end
			end
			S_T_CHK: j_q <= '0;
			S_F_WAIT: begin
				if (div_done) begin
					face_q[j_q] <= face_v;
					j_q <= j_q + 1'b1;
					cidx_q <= '0;
				end
			end
			S_A_WR: cidx_q <= cidx_q + 1'b1;
			S_R_CAP: begin
				for (int e = 0; e < 6; e++)
					v_q[e] <= acc_rd_q[(5-e)*ACC_W +: ACC_W];
				zf_q  <= 1'b0;
				sel_q <= 1'b0;
			end
			S_N_MAG: begin
				for (int i = 0; i < 3; i++)
					m_q[i] <= mag_c[i];
				mx_q <= mx_c;
				if (mx_c == '0) begin
					zf_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						res_q[sel_q ? 3 + i : i] <= '0;
					sel_q <= 1'b1;
				end
			end
			S_N_SH: begin
				// truncating shift until the largest magnitude fits
				if (mx_q[ACC_W-1:NRM_W] != '0) begin
					mx_q <= mx_q >> 1;
					for (int i = 0; i < 3; i++)
						m_q[i] <= m_q[i] >> 1;
				end else begin
					k_q   <= '0;
					sum_q <= '0;
				end
			end
			S_N_SQ: begin
				k_q <= k_q + 1'b1;
				if (k_q != '0)
					sum_q <= sum_q + SQ_W'(prod_s1);
			end
			S_N_RT_WAIT: begin
				if (rt_done) begin
					n_q <= rt_root;
					j_q <= '0;
				end
			end
			S_D_WAIT: begin
				if (div_done) begin
					res_q[ridx] <= res_v;
					j_q <= j_q + 1'b1;
					if (j_q == 3'd2)
						sel_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign tangent_x   = res_q[0];
	assign tangent_y   = res_q[1];
	assign tangent_z   = res_q[2];
	assign bitangent_x = res_q[3];
	assign bitangent_y = res_q[4];
	assign bitangent_z = res_q[5];
	assign zero_vector = zf_q;

	// ---------------- assertions ----------------
	`MTSB_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
	`MTSB_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while sequencer still busy")
	`MTSB_ASSERT_NOW(a_rmw_order, state_q == S_A_WR, $past(state_q == S_A_RD),
		"accumulator write-back without a preceding read")

endmodule

// ----- dv/mtsb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh tangent space builder: checker
// Watches the command and result channels, keeps its own copy of the vertex
// store, predicts each vertex read and compares it with the whole result word.
// ----------------------------------------------------------------------------
module mtsb_checker import mtsb_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [1:0]              mode,
	input  logic [9:0]              vertex_index,
	input  logic [9:0]              corner_b_index,
	input  logic [9:0]              corner_c_index,
	input  logic signed [POS_W-1:0] vec_x,
	input  logic signed [POS_W-1:0] vec_y,
	input  logic signed [POS_W-1:0] vec_z,
	input  logic signed [UV_W-1:0]  tex_u,
	input  logic signed [UV_W-1:0]  tex_v,
	input  logic signed [OUT_W-1:0] vec2_x,
	input  logic signed [OUT_W-1:0] vec2_y,
	input  logic signed [OUT_W-1:0] vec2_z,
	input  logic                    done,
	input  logic signed [OUT_W-1:0] tangent_x,
	input  logic signed [OUT_W-1:0] tangent_y,
	input  logic signed [OUT_W-1:0] tangent_z,
	input  logic signed [OUT_W-1:0] bitangent_x,
	input  logic signed [OUT_W-1:0] bitangent_y,
	input  logic signed [OUT_W-1:0] bitangent_z,
	input  logic                    zero_vector,
	output int                      errors,
	output int                      pending
);

	typedef struct packed {
		logic signed [15:0] tx, ty, tz, bx, by, bz;
		logic               zv;
	} vertex_read_t;

	localparam longint SAT_HI = 64'sd549755813887;
	localparam longint SAT_LO = -SAT_HI - 1;

	longint pos_mem [1024][3];
	longint uv_mem  [1024][2];
	longint tan_sum [1024][3];
	longint bit_sum [1024][3];

	vertex_read_t expected_reads [$];

	function automatic longint sat40(input longint x);
		if (x > SAT_HI) return SAT_HI;
		if (x < SAT_LO) return SAT_LO;
		return x;
	endfunction

	function automatic logic [63:0] abs64(input longint x);
		return x < 0 ? 64'd0 - 64'(x) : 64'(x);
	endfunction

	// num * 1024 / den, nearest, ties away from zero, clamped to 40 bits
	function automatic longint face_component(input longint num, input longint den);
		logic [63:0] n, d, q;
		n = abs64(num);
		d = abs64(den);
		q = (n * 64'd1024 + d / 64'd2) / d;
		if ((num < 0) != (den < 0))
			return q > 64'(SAT_HI) + 64'd1 ? SAT_LO : -longint'(q);
		return q > 64'(SAT_HI) ? SAT_HI : longint'(q);
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit vector in Q2.14; returns 1 for an all-zero vector
	function automatic logic unit_vector(input longint c0, c1, c2,
			output logic [15:0] o0, o1, o2);
		logic [63:0] m [3];
		logic [63:0] mx, sq, n, q;
		longint c [3];
		c[0] = c0; c[1] = c1; c[2] = c2;
		mx = 0;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = abs64(c[i]);
			if (m[i] > mx) mx = m[i];
		end
		o0 = 0; o1 = 0; o2 = 0;
		if (mx == 0) return 1'b1;
		while (mx >= (64'd1 << NRM_W)) begin
			mx = mx >> 1;
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
		end
		for (int i = 0; i < 3; i++) sq = sq + m[i] * m[i];
		n = root_floor(sq);
		for (int i = 0; i < 3; i++) begin
			q = (m[i] * 64'd16384 + n / 64'd2) / n;
			if (c[i] < 0) q = 64'd0 - q;
			if (i == 0) o0 = q[15:0];
			else if (i == 1) o1 = q[15:0];
			else o2 = q[15:0];
		end
		return 1'b0;
	endfunction

	function automatic void add_face(input int k, input longint t [3], input longint b [3]);
		for (int i = 0; i < 3; i++) begin
			tan_sum[k][i] = sat40(tan_sum[k][i] + t[i]);
			bit_sum[k][i] = sat40(bit_sum[k][i] + b[i]);
		end
	endfunction

	function automatic void apply_triangle(input int a, b, c);
		longint du1, dv1, du2, dv2, det, e1, e2;
		longint t [3];
		longint bt [3];
		du1 = uv_mem[b][0] - uv_mem[a][0];
		dv1 = uv_mem[b][1] - uv_mem[a][1];
		du2 = uv_mem[c][0] - uv_mem[a][0];
		dv2 = uv_mem[c][1] - uv_mem[a][1];
		det = du1 * dv2 - du2 * dv1;
		if (det == 0) return;   // degenerate uv, face skipped
		for (int i = 0; i < 3; i++) begin
			e1 = pos_mem[b][i] - pos_mem[a][i];
			e2 = pos_mem[c][i] - pos_mem[a][i];
			t[i]  = face_component(dv2 * e1 - dv1 * e2, det);
			bt[i] = face_component(du1 * e2 - du2 * e1, det);
		end
		add_face(a, t, bt);
		add_face(b, t, bt);
		add_face(c, t, bt);
	endfunction

	function automatic vertex_read_t predict_read(input int a);
		vertex_read_t r;
		logic zt, zb;
		zt = unit_vector(tan_sum[a][0], tan_sum[a][1], tan_sum[a][2], r.tx, r.ty, r.tz);
		zb = unit_vector(bit_sum[a][0], bit_sum[a][1], bit_sum[a][2], r.bx, r.by, r.bz);
		r.zv = zt | zb;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vertex_read_t got, want;
		if (!arst_n) begin
			errors = 0;
			expected_reads.delete();
		end else begin
			if (done) begin
				got = '{tangent_x, tangent_y, tangent_z,
					bitangent_x, bitangent_y, bitangent_z, zero_vector};
				if (expected_reads.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result word t=%0d,%0d,%0d b=%0d,%0d,%0d zv=%0b",
							got.tx, got.ty, got.tz, got.bx, got.by, got.bz, got.zv);
				end else begin
					want = expected_reads.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("read mismatch: exp t=%0d,%0d,%0d b=%0d,%0d,%0d zv=%0b / got t=%0d,%0d,%0d b=%0d,%0d,%0d zv=%0b",
								want.tx, want.ty, want.tz, want.bx, want.by, want.bz, want.zv,
								got.tx, got.ty, got.tz, got.bx, got.by, got.bz, got.zv);
					end
				end
			end
			if (start && !busy) begin
				case (mode)
					MODE_LOAD_PU: begin
						pos_mem[vertex_index][0] = longint'(vec_x);
						pos_mem[vertex_index][1] = longint'(vec_y);
						pos_mem[vertex_index][2] = longint'(vec_z);
						uv_mem[vertex_index][0]  = longint'(tex_u);
						uv_mem[vertex_index][1]  = longint'(tex_v);
					end
					MODE_LOAD_VEC: begin
						tan_sum[vertex_index][0] = longint'(vec_x);
						tan_sum[vertex_index][1] = longint'(vec_y);
						tan_sum[vertex_index][2] = longint'(vec_z);
						bit_sum[vertex_index][0] = longint'(vec2_x);
						bit_sum[vertex_index][1] = longint'(vec2_y);
						bit_sum[vertex_index][2] = longint'(vec2_z);
					end
					MODE_TRI:
						apply_triangle(vertex_index, corner_b_index, corner_c_index);
					default:
						expected_reads.insert(expected_reads.size(),
							predict_read(vertex_index));
				endcase
			end
		end
		pending = expected_reads.size();
	end

endmodule

// ----- dv/mesh_tangent_space_builder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mesh tangent space builder: testbench top
// Loads vertex pools, issues triangles and vertex reads with directed corner
// cases and random traffic under several sender idle rates; the checker
// predicts every read and reports mismatches.
// ----------------------------------------------------------------------------
module mesh_tangent_space_builder_tb;
	import mtsb_pkg::*;

	typedef struct {
		logic [1:0]  md;
		logic [9:0]  a, b, c;
		logic [31:0] x, y, z;
		logic [15:0] u, v, bx, by, bz;
	} cmd_word_t;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              mode;
	logic [9:0]              vertex_index;
	logic [9:0]              corner_b_index;
	logic [9:0]              corner_c_index;
	logic signed [POS_W-1:0] vec_x, vec_y, vec_z;
	logic signed [UV_W-1:0]  tex_u, tex_v;
	logic signed [OUT_W-1:0] vec2_x, vec2_y, vec2_z;
	logic                    done;
	logic signed [OUT_W-1:0] tangent_x, tangent_y, tangent_z;
	logic signed [OUT_W-1:0] bitangent_x, bitangent_y, bitangent_z;
	logic                    zero_vector;
	int                      errors;
	int                      pending;

	int idle_pct;
	bit has_pu  [1024];
	bit has_vec [1024];
	int pool [$];

	mesh_tangent_space_builder dut (.*);

	mtsb_checker chk (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	initial begin
		#30_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_word(input cmd_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
		end
		@(negedge clk);
		start = 1'b1;
		mode = w.md;
		vertex_index = w.a; corner_b_index = w.b; corner_c_index = w.c;
		vec_x = w.x; vec_y = w.y; vec_z = w.z;
		tex_u = w.u; tex_v = w.v;
		vec2_x = w.bx; vec2_y = w.by; vec2_z = w.bz;
		while (busy) @(negedge clk);
		@(posedge clk);
		if (w.md == MODE_LOAD_PU) has_pu[w.a] = 1'b1;
		if (w.md == MODE_LOAD_VEC) has_vec[w.a] = 1'b1;
	endtask

	function automatic cmd_word_t noise_word(input logic [1:0] md, input int a, b, c);
		cmd_word_t w;
		w.md = md; w.a = 10'(a); w.b = 10'(b); w.c = 10'(c);
		w.x = $urandom; w.y = $urandom; w.z = $urandom;
		w.u = 16'($urandom); w.v = 16'($urandom);
		w.bx = 16'($urandom); w.by = 16'($urandom); w.bz = 16'($urandom);
		return w;
	endfunction

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(9))
			0, 1:    return $urandom;
			2:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(1 << 21)) - (1 << 20));
		endcase
	endfunction

	function automatic logic [15:0] rand_uv();
		case ($urandom_range(9))
			0:       return 16'($urandom);
			1:       return $urandom_range(1) ? 16'h1000 : 16'h0000;  // collinear uv
			default: return 16'($signed($urandom_range(8192)) - 4096);
		endcase
	endfunction

	function automatic cmd_word_t pu_word(input int a);
		cmd_word_t w;
		w = noise_word(MODE_LOAD_PU, a, $urandom, $urandom);
		w.x = rand_pos(); w.y = rand_pos(); w.z = rand_pos();
		w.u = rand_uv(); w.v = rand_uv();
		return w;
	endfunction

	function automatic cmd_word_t vec_word(input int a);
		cmd_word_t w;
		w = noise_word(MODE_LOAD_VEC, a, $urandom, $urandom);
		if ($urandom_range(5) == 0) begin
			w.x = 0; w.y = 0; w.z = 0;
		end else if ($urandom_range(3) != 0) begin
			w.x = 32'($signed($urandom_range(32768)) - 16384);
			w.y = 32'($signed($urandom_range(32768)) - 16384);
			w.z = 32'($signed($urandom_range(32768)) - 16384);
		end
		if ($urandom_range(5) == 0) begin
			w.bx = 0; w.by = 0; w.bz = 0;
		end
		return w;
	endfunction

	task automatic set_vertex(input int a, input logic [31:0] x, y, z,
			input logic [15:0] u, v, input logic [31:0] tx, ty, tz,
			input logic [15:0] bx, by, bz);
		cmd_word_t w;
		w = noise_word(MODE_LOAD_PU, a, 0, 0);
		w.x = x; w.y = y; w.z = z; w.u = u; w.v = v;
		send_word(w);
		w = noise_word(MODE_LOAD_VEC, a, 0, 0);
		w.x = tx; w.y = ty; w.z = tz; w.bx = bx; w.by = by; w.bz = bz;
		send_word(w);
	endtask

	task automatic wait_drained();
		// stop offering the last word again while the block drains
		@(negedge clk);
		start = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic random_phase(input int items);
		int a, n;
		pool.delete();
		while (pool.size() < 24) begin
			a = $urandom_range(1023);
			send_word(pu_word(a));
			send_word(vec_word(a));
			pool.insert(pool.size(), a);
		end
		n = 48;
		while (n < items) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9:
					send_word(noise_word(MODE_TRI, pool[$urandom_range(23)],
						pool[$urandom_range(23)], pool[$urandom_range(23)]));
				10, 11, 12, 13, 14, 15:
					send_word(noise_word(MODE_READ, pool[$urandom_range(23)], 0, 0));
				16, 17:
					send_word(pu_word(pool[$urandom_range(23)]));
				default:
					send_word(vec_word(pool[$urandom_range(23)]));
			endcase
			n++;
		end
	endtask

	initial begin
		cmd_word_t w;
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_LOAD_PU;
		vertex_index = 0; corner_b_index = 0; corner_c_index = 0;
		vec_x = 0; vec_y = 0; vec_z = 0;
		tex_u = 0; tex_v = 0;
		vec2_x = 0; vec2_y = 0; vec2_z = 0;
		idle_pct = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extreme positions, uv and starting vectors
		set_vertex(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h8000, 16'h8000,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'h7fff, 16'h8000, 16'h7fff);
		set_vertex(1023, 32'h80000000, 32'h80000000, 32'h80000000, 16'h7fff, 16'h8000,
			32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000, 16'h8000);
		set_vertex(682, 0, 0, 0, 16'h8000, 16'h7fff, 0, 0, 0, 0, 0, 0);
		send_word(noise_word(MODE_READ, 682, 0, 0));   // zero vectors
		send_word(noise_word(MODE_READ, 0, 0, 0));
		send_word(noise_word(MODE_READ, 1023, 0, 0));
		send_word(noise_word(MODE_TRI, 0, 1023, 682));
		send_word(noise_word(MODE_TRI, 0, 0, 682));    // repeated corner
		send_word(noise_word(MODE_READ, 682, 0, 0));
		send_word(noise_word(MODE_READ, 0, 0, 0));
		// unit uv determinant with huge edges drives the sums into saturation
		set_vertex(341, 32'h80000000, 0, 32'h7fffffff, 0, 0, 0, 0, 16384, 0, 16384, 0);
		set_vertex(5, 32'h7fffffff, 32'h80000000, 0, 1, 0, 16384, 0, 0, 0, 0, 16384);
		set_vertex(6, 0, 32'h7fffffff, 32'h80000000, 0, 1, 0, 16384, 0, 16384, 0, 0);
		send_word(noise_word(MODE_TRI, 341, 5, 6));
		send_word(noise_word(MODE_TRI, 341, 5, 6));
		send_word(noise_word(MODE_READ, 341, 0, 0));
		send_word(noise_word(MODE_TRI, 341, 682, 682)); // degenerate uv
		send_word(noise_word(MODE_READ, 6, 0, 0));
		wait_drained();

		idle_pct = 0;  random_phase(310); wait_drained();
		idle_pct = 84; random_phase(310); wait_drained();
		idle_pct = 84; random_phase(300); wait_drained();
		idle_pct = 14; random_phase(310);

		@(negedge clk);
		start = 1'b0;
		wait_drained();
		if (errors == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
